[hw/rtl/fsle_pkg.sv]
// fsle_pkg: shared sizes and controller/datapath interface types for the
// first-seen level encoder. No dependencies.
package fsle_pkg;

    localparam int MAX_LEVELS = 64;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_BITS  = $clog2(MAX_LEVELS);
    localparam int LEVEL_BITS = $clog2(MAX_LEVELS + 1);

    localparam logic [LEVEL_BITS-1:0] LIMIT_RESET = LEVEL_BITS'(MAX_LEVELS);

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle: latch key, clear scan
        logic scan;     // walk the table
        logic finish;   // load the result register, append on a miss with room
    } fsle_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic done;     // match found or table exhausted
        logic out_free; // result register can take a new result
    } fsle_status_t;

endpackage

[hw/rtl/fsle_ctrl.sv]
// fsle_ctrl: sequencing state machine of the first-seen level encoder.
// Depends on fsle_pkg for the command and status types.
module fsle_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fsle_pkg::fsle_status_t status,
    output fsle_pkg::fsle_cmd_t   cmd
);
    import fsle_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands decoded from the current state
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        cmd.accept = (state_reg == ST_IDLE) && s_valid;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.finish = (state_reg == ST_FINISH) && status.out_free;
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/fsle_datapath.sv]
// fsle_datapath: value table, scan pipeline, count and limit registers and
// the result register of the first-seen level encoder. Depends on fsle_pkg.
module fsle_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fsle_pkg::fsle_cmd_t                 cmd,
    output fsle_pkg::fsle_status_t              status,
    input  logic                                cfg_we,
    input  logic [fsle_pkg::LEVEL_BITS-1:0]     cfg_wdata,
    input  logic signed [fsle_pkg::VALUE_BITS-1:0] s_value,
    input  logic                                s_starts_set,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fsle_pkg::LEVEL_BITS-1:0]     m_level,
    output logic                                m_is_new,
    output logic [fsle_pkg::LEVEL_BITS-1:0]     m_distinct_count,
    output logic                                m_overflow
);
    import fsle_pkg::*;

    // table of distinct values, in first-seen order
    logic [VALUE_BITS-1:0] seen_mem [MAX_LEVELS];

    logic [VALUE_BITS-1:0] key_reg;
    logic [LEVEL_BITS-1:0] count_reg;
    logic [LEVEL_BITS-1:0] limit_reg;
    logic [LEVEL_BITS-1:0] issue_idx_reg;
    logic                  rd_valid_reg;
    logic [ADDR_BITS-1:0]  rd_idx_reg;
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  found_reg;
    logic [ADDR_BITS-1:0]  found_idx_reg;

    logic                  m_valid_reg;
    logic [LEVEL_BITS-1:0] level_reg;
    logic                  is_new_reg;
    logic [LEVEL_BITS-1:0] distinct_reg;
    logic                  overflow_reg;

    logic                  more;
    logic                  issue;
    logic                  hit;
    logic                  room;

    // scan control: one table read issued per cycle until a match or the end of the filled table
    assign more  = (issue_idx_reg < count_reg);
    assign issue = cmd.scan && !found_reg && more;
    assign hit   = rd_valid_reg && (rdata_reg == key_reg);
    assign room  = (count_reg < limit_reg) && (count_reg < LEVEL_BITS'(MAX_LEVELS));

    assign status.done     = found_reg || (!more && !rd_valid_reg);
    assign status.out_free = !m_valid_reg || m_ready;

    // table port: registered read while scanning, append on a miss with room
    always_ff @(posedge aclk) begin
        rdata_reg <= seen_mem[issue_idx_reg[ADDR_BITS-1:0]];
        if (cmd.finish && !found_reg && room) begin
            seen_mem[count_reg[ADDR_BITS-1:0]] <= key_reg;
        end
    end

    // scan pipeline and match capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
        end else if (cmd.accept) begin
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
            if (issue) begin
                issue_idx_reg <= issue_idx_reg + LEVEL_BITS'(1);
            end
            if (cmd.scan && hit && !found_reg) begin
                found_reg <= 1'b1;
            end
        end
    end

    // payload of the scan, no reset needed
    always_ff @(posedge aclk) begin
        rd_idx_reg <= issue_idx_reg[ADDR_BITS-1:0];
        if (cmd.accept) begin
            key_reg <= s_value;
        end
        if (cmd.scan && hit && !found_reg) begin
            found_idx_reg <= rd_idx_reg;
        end
    end

    // distinct count and level limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.accept && s_starts_set) begin
                count_reg <= '0;
            end else if (cmd.finish && !found_reg && room) begin
                count_reg <= count_reg + LEVEL_BITS'(1);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (found_reg) begin
                level_reg    <= LEVEL_BITS'(found_idx_reg) + LEVEL_BITS'(1);
                is_new_reg   <= 1'b0;
                distinct_reg <= count_reg;
                overflow_reg <= 1'b0;
            end else if (room) begin
                level_reg    <= count_reg + LEVEL_BITS'(1);
                is_new_reg   <= 1'b1;
                distinct_reg <= count_reg + LEVEL_BITS'(1);
                overflow_reg <= 1'b0;
            end else begin
                level_reg    <= '0;
                is_new_reg   <= 1'b1;
                distinct_reg <= count_reg;
                overflow_reg <= 1'b1;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_level          = level_reg;
    assign m_is_new         = is_new_reg;
    assign m_distinct_count = distinct_reg;
    assign m_overflow       = overflow_reg;

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LEVEL_BITS'(MAX_LEVELS))
        else $error("distinct count beyond table depth");

    // a captured match always lies inside the filled part of the table
    a_found_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (LEVEL_BITS'(found_idx_reg) < count_reg))
        else $error("match index outside filled table");

    // count only shrinks when a new set starts
    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.accept && s_starts_set) |=> (count_reg >= $past(count_reg)))
        else $error("distinct count dropped without set start");

    // an overflow result carries level zero
    a_overflow_level: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (!overflow_reg || (level_reg == '0)))
        else $error("overflow result with non-zero level");

endmodule

[hw/rtl/first_seen_level_encoder_core.sv]
// Top level of the first-seen level encoder: controller plus datapath.
// Depends on fsle_pkg, fsle_ctrl and fsle_datapath.
//
// Each input value gets its level, the 1-based position of that value in the
// order the distinct values of the current set first appeared; starts_set
// empties the table before the item is looked up. A new value past the
// level limit (cfg_wdata, reset 64, capped at the 64-entry table) gives level
// 0 with overflow and is not stored. The table is a memory with one read and
// one write port, searched one entry per cycle, so the time from input
// transfer to result grows with the number of entries scanned, and is longer
// while a previous result still waits on m_ready. The next input can be taken
// in the cycle after the result reaches the output register, which holds it
// until the result transfer. No clearing pass is needed after reset.
module first_seen_level_encoder_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [fsle_pkg::LEVEL_BITS-1:0]        cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [fsle_pkg::VALUE_BITS-1:0] s_value,
    input  logic                                   s_starts_set,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [fsle_pkg::LEVEL_BITS-1:0]        m_level,
    output logic                                   m_is_new,
    output logic [fsle_pkg::LEVEL_BITS-1:0]        m_distinct_count,
    output logic                                   m_overflow
);
    import fsle_pkg::*;

    fsle_cmd_t    cmd;
    fsle_status_t status;

    // sequencing
    fsle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // table, scan and result register
    fsle_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_value          (s_value),
        .s_starts_set     (s_starts_set),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_level          (m_level),
        .m_is_new         (m_is_new),
        .m_distinct_count (m_distinct_count),
        .m_overflow       (m_overflow)
    );

endmodule
